>>> rtl/core/chp_pkg.sv
// chp_pkg: constants, types and control store for the cascaded high-pass block
// shared by chp_datapath and cascaded_highpass_multichannel_top, no dependencies
package chp_pkg;

    localparam int CHANNELS = 8;
    localparam int SECTIONS = 3;
    localparam int DEPTH    = SECTIONS * CHANNELS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 19;
    localparam int FRAC     = 18;
    localparam int COEF_W   = GAIN_W + 2;          // signed 2k - 2^18
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = COEF_W + DIFF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int SHIFT_W  = SUM_W - FRAC;
    localparam int WORD_W   = 2 * SAMPLE_W;        // {x_prev, y_prev}
    localparam int PC_W     = 4;
    localparam int IDX_W    = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_GAIN_ONE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_TWO   = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_THREE = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_ONE_RST   = 19'd254157;
    localparam logic [GAIN_W-1:0] GAIN_TWO_RST   = 19'd253299;
    localparam logic [GAIN_W-1:0] GAIN_THREE_RST = 19'd252446;

    typedef enum logic [2:0] {
        UOP_IDLE     = 3'd0,
        UOP_MUL_DIFF = 3'd1,
        UOP_MUL_FB   = 3'd2,
        UOP_WRITE    = 3'd3,
        UOP_FINISH   = 3'd4
    } t_uop;

    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_IN_VALID = 2'd1,
        COND_OUT_FREE = 2'd2
    } t_cond;

    typedef struct packed {
        t_uop            op;
        logic [1:0]      sec;
        t_cond           cond;
        logic [PC_W-1:0] next;
    } t_ucode;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       mul_diff;
        logic       mul_fb;
        logic       wr;
        logic [1:0] sec;
    } t_dp_ctrl;

    // control store: jump to next when cond holds, else hold the step
    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode uc;
        case (pc)
            4'd0:    uc = '{UOP_IDLE,     2'd0, COND_IN_VALID, 4'd1};
            4'd1:    uc = '{UOP_MUL_DIFF, 2'd0, COND_ALWAYS,   4'd2};
            4'd2:    uc = '{UOP_MUL_FB,   2'd0, COND_ALWAYS,   4'd3};
            4'd3:    uc = '{UOP_WRITE,    2'd0, COND_ALWAYS,   4'd4};
            4'd4:    uc = '{UOP_MUL_DIFF, 2'd1, COND_ALWAYS,   4'd5};
            4'd5:    uc = '{UOP_MUL_FB,   2'd1, COND_ALWAYS,   4'd6};
            4'd6:    uc = '{UOP_WRITE,    2'd1, COND_ALWAYS,   4'd7};
            4'd7:    uc = '{UOP_MUL_DIFF, 2'd2, COND_ALWAYS,   4'd8};
            4'd8:    uc = '{UOP_MUL_FB,   2'd2, COND_ALWAYS,   4'd9};
            4'd9:    uc = '{UOP_WRITE,    2'd2, COND_ALWAYS,   4'd10};
            4'd10:   uc = '{UOP_FINISH,   2'd0, COND_OUT_FREE, 4'd0};
            default: uc = '{UOP_IDLE,     2'd0, COND_ALWAYS,   4'd0};
        endcase
        return uc;
    endfunction

endpackage

>>> rtl/core/chp_datapath.sv
// chp_datapath: per-channel section state memory, shared multiplier, round and saturate
// depends on chp_pkg, driven by the sequencer in cascaded_highpass_multichannel_top
module chp_datapath import chp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_ctrl                      i_ctrl,
    input  logic [CH_W-1:0]               i_ch,
    input  logic signed [SAMPLE_W-1:0]    i_sample,
    input  logic [SECTIONS-1:0][GAIN_W-1:0] i_gain,
    output logic signed [SAMPLE_W-1:0]    o_y
);

    localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'(8388607);
    localparam logic signed [SHIFT_W-1:0] SAT_LO = -SHIFT_W'(8388608);
    localparam logic signed [SUM_W-1:0]   HALF   = SUM_W'(1) <<< (FRAC - 1);

    logic [WORD_W-1:0]          r_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic [WORD_W-1:0]          r_rd_word;
    logic                       r_rd_vld;
    logic [ADDR_W-1:0]          r_addr;
    logic                       r_chok;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_yp;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_acc;

    logic                       ch_ok_in;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       n_rd_vld;
    logic [GAIN_W-1:0]          gain;
    logic signed [SAMPLE_W-1:0] x_prev;
    logic signed [SAMPLE_W-1:0] y_prev;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [COEF_W-1:0]   coef;
    logic signed [COEF_W-1:0]   mul_a;
    logic signed [DIFF_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SHIFT_W-1:0]  shifted;
    logic signed [SAMPLE_W-1:0] y_sat;

    assign ch_ok_in = ({1'b0, i_ch} < (CH_W + 1)'(CHANNELS));

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr + ADDR_W'(CHANNELS);
        if (i_ctrl.load) begin
            rd_en   = ch_ok_in;
            rd_addr = ADDR_W'(i_ch);
        end else if (i_ctrl.wr) begin
            // fetch the next section's state while this one writes back
            rd_en = r_chok && (i_ctrl.sec != 2'(SECTIONS - 1));
        end
        n_rd_vld = rd_en ? (r_vld[rd_addr] && !(i_ctrl.load && i_ctrl.clear)) : 1'b0;
    end

    always_comb begin
        case (i_ctrl.sec)
            2'd0:    gain = i_gain[0];
            2'd1:    gain = i_gain[1];
            2'd2:    gain = i_gain[2];
            default: gain = i_gain[0];
        endcase
        x_prev  = r_rd_vld ? $signed(r_rd_word[WORD_W-1:SAMPLE_W]) : '0;
        y_prev  = r_rd_vld ? $signed(r_rd_word[SAMPLE_W-1:0]) : '0;
        diff    = {r_x[SAMPLE_W-1], r_x} - {x_prev[SAMPLE_W-1], x_prev};
        coef    = $signed({1'b0, gain, 1'b0}) - $signed(COEF_W'(1) << FRAC);
        if (i_ctrl.mul_fb) begin
            mul_a = coef;
            mul_b = {r_yp[SAMPLE_W-1], r_yp};
        end else begin
            mul_a = $signed({2'b00, gain});
            mul_b = diff;
        end
        mul_p   = mul_a * mul_b;
        sum     = {r_acc[PROD_W-1], r_acc} + {r_prod[PROD_W-1], r_prod} + HALF;
        shifted = sum[SUM_W-1:FRAC];
        if (shifted > SAT_HI) begin
            y_sat = SAMPLE_W'(SAT_HI);
        end else if (shifted < SAT_LO) begin
            y_sat = SAMPLE_W'(SAT_LO);
        end else begin
            y_sat = shifted[SAMPLE_W-1:0];
        end
    end

    // state memory: stored word is {section input, section output}
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr && r_chok) begin
            r_mem[r_addr] <= {r_x, y_sat};
        end
        if (rd_en) begin
            r_rd_word <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_chok   <= 1'b0;
        end else begin
            if (i_ctrl.load && i_ctrl.clear) begin
                r_vld <= '0;
            end else if (i_ctrl.wr && r_chok) begin
                r_vld[r_addr] <= 1'b1;
            end
            if (i_ctrl.load || i_ctrl.wr) begin
                r_rd_vld <= n_rd_vld;
            end
            if (i_ctrl.load) begin
                r_chok <= ch_ok_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x    <= i_sample;
            r_addr <= ADDR_W'(i_ch);
        end
        if (i_ctrl.mul_diff) begin
            r_prod <= mul_p;
            r_yp   <= y_prev;
        end
        if (i_ctrl.mul_fb) begin
            r_acc  <= r_prod;
            r_prod <= mul_p;
        end
        if (i_ctrl.wr) begin
            r_x    <= y_sat;
            r_addr <= r_addr + ADDR_W'(CHANNELS);
        end
    end

    assign o_y = r_chok ? r_x : '0;

endmodule

>>> rtl/core/cascaded_highpass_multichannel_top.sv
// cascaded_highpass_multichannel_top: three cascaded first-order high-pass sections
// over interleaved channels; uses chp_pkg and chp_datapath
//
//  channel  direction  ports                  payload
//  s        in         i_s_tvalid/o_s_tready  tdata: channel, sample; tuser: clear toggle
//  m        out        o_m_tvalid/i_m_tready  tdata: channel, filtered sample
//  cfg      in         i_cfg_we               i_cfg_idx, i_cfg_wdata (gains, Q1.18)
//
// one word runs through an accept step, then three steps per section on the
// single shared multiplier (difference product, feedback product, round and write back),
// then a step that loads the output register. the output register lets the next word
// be accepted while a result waits. a clear toggle change drops the per-entry valid
// bits at once, so there is no clearing pass. reset is synchronous, active low.
module cascaded_highpass_multichannel_top import chp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,   // [2:0] channel_index, [26:3] sample_in, zero pad
    input  logic              i_s_tuser,   // [0] clear_toggle
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [31:0]       o_m_tdata,   // [2:0] channel_out, [26:3] sample_out, zero pad
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [GAIN_W-1:0] i_cfg_wdata
);

    logic [PC_W-1:0]              r_pc;
    logic [PC_W-1:0]              n_pc;
    logic                         r_last_toggle;
    logic [CH_W-1:0]              r_ch;
    logic [SECTIONS-1:0][GAIN_W-1:0] r_gain;
    logic                         r_out_valid;
    logic [CH_W-1:0]              r_out_ch;
    logic signed [SAMPLE_W-1:0]   r_out_sample;

    t_ucode                       uc;
    t_dp_ctrl                     dp_ctrl;
    logic                         accept;
    logic                         out_free;
    logic                         cond_ok;
    logic signed [SAMPLE_W-1:0]   dp_y;

    assign uc       = ucode_rom(r_pc);
    assign out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (uc.op == UOP_IDLE);
    assign accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        case (uc.cond)
            COND_ALWAYS:   cond_ok = 1'b1;
            COND_IN_VALID: cond_ok = i_s_tvalid;
            COND_OUT_FREE: cond_ok = out_free;
            default:       cond_ok = 1'b1;
        endcase
        n_pc = cond_ok ? uc.next : r_pc;
    end

    always_comb begin
        dp_ctrl.load     = accept;
        dp_ctrl.clear    = (i_s_tuser != r_last_toggle);
        dp_ctrl.mul_diff = (uc.op == UOP_MUL_DIFF);
        dp_ctrl.mul_fb   = (uc.op == UOP_MUL_FB);
        dp_ctrl.wr       = (uc.op == UOP_WRITE);
        dp_ctrl.sec      = uc.sec;
    end

    chp_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (dp_ctrl),
        .i_ch     (i_s_tdata[CH_W-1:0]),
        .i_sample (i_s_tdata[CH_W+SAMPLE_W-1:CH_W]),
        .i_gain   (r_gain),
        .o_y      (dp_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc          <= '0;
            r_last_toggle <= 1'b0;
            r_out_valid   <= 1'b0;
            r_gain[0]     <= GAIN_ONE_RST;
            r_gain[1]     <= GAIN_TWO_RST;
            r_gain[2]     <= GAIN_THREE_RST;
        end else begin
            r_pc <= n_pc;
            if (accept) begin
                r_last_toggle <= i_s_tuser;
            end
            if (uc.op == UOP_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GAIN_ONE:   r_gain[0] <= i_cfg_wdata;
                    REG_GAIN_TWO:   r_gain[1] <= i_cfg_wdata;
                    REG_GAIN_THREE: r_gain[2] <= i_cfg_wdata;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch <= i_s_tdata[CH_W-1:0];
        end
        if (uc.op == UOP_FINISH && out_free) begin
            r_out_ch     <= r_ch;
            r_out_sample <= dp_y;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_sample, r_out_ch};

endmodule
